/* src/ngrl_pkg.sv */
package ngrl_pkg;

   localparam int MAX_REGIONS_DEF = 256;
   localparam int ID_W   = 22;
   localparam int CELL_W = 11;
   localparam int PT_W   = 20;
   localparam int DIST_W = 46;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_HIT     = 3'd2;
   localparam logic [2:0] ST_NEAREST = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   // data moving along the cell row
   typedef struct packed {
      logic              valid;
      logic              is_query;
      logic [ID_W-1:0]   key;
      logic signed [PT_W-1:0] px;
      logic signed [PT_W-1:0] py;
      logic              match;
      logic              have;
      logic [DIST_W-1:0] best_d;
      logic [ID_W-1:0]   best_id;
   } probe_type;

   function automatic logic signed [CELL_W-1:0] id_gx(input logic [ID_W-1:0] id);
      id_gx = signed'(id[ID_W-1:CELL_W] ^ 11'h400);
   endfunction

   function automatic logic signed [CELL_W-1:0] id_gy(input logic [ID_W-1:0] id);
      id_gy = signed'(id[CELL_W-1:0] ^ 11'h400);
   endfunction

   function automatic logic [ID_W-1:0] pack_id(input logic signed [CELL_W-1:0] gx,
                                               input logic signed [CELL_W-1:0] gy);
      pack_id = {gx ^ 11'h400, gy ^ 11'h400};
   endfunction

endpackage

/* src/ngrl_cell.sv */
module ngrl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  wr_en,
   input  logic [ngrl_pkg::ID_W-1:0] wr_id,
   input  ngrl_pkg::probe_type   probe_in,
   output ngrl_pkg::probe_type   probe_out
);

   logic                        used_ff, used_in;
   logic [ngrl_pkg::ID_W-1:0]   id_ff;
   ngrl_pkg::probe_type         probe_ff, probe_in_c;
   logic signed [ngrl_pkg::PT_W+3:0] dx, dy;
   logic [ngrl_pkg::DIST_W-1:0] d;

   always_comb begin
      dx = 24'(probe_in.px) - 24'(signed'({ngrl_pkg::id_gx(id_ff), 12'd0}));
      dy = 24'(probe_in.py) - 24'(signed'({ngrl_pkg::id_gy(id_ff), 12'd0}));
      d  = ngrl_pkg::DIST_W'(dx * dx) + ngrl_pkg::DIST_W'(dy * dy);
      probe_in_c = probe_in;
      if (probe_in.valid && used_ff) begin
         if (id_ff == probe_in.key) probe_in_c.match = 1'b1;
         if (probe_in.is_query && (!probe_in.have || d < probe_in.best_d)) begin
            probe_in_c.have    = 1'b1;
            probe_in_c.best_d  = d;
            probe_in_c.best_id = id_ff;
         end
      end
      used_in = clear ? 1'b0 : (wr_en ? 1'b1 : used_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         used_ff  <= used_in;
         probe_ff <= probe_in_c;
      end
      if (wr_en) id_ff <= wr_id;
   end

   assign probe_out = probe_ff;

endmodule

/* src/nearest_grid_region_lookup.sv */
// channel  | ports                                  | handshake
// request  | req_op, req_cell_*, req_point_*        | start & !busy
// response | rsp_status, rsp_grid_key, rsp_found_*  | rsp_strobe, one cycle
// Loads and queries walk the cell row, one cell per cycle: the response is registered
// from the last cell's output, and the next request is accepted after the response.
// Clear and no-op respond the next cycle.
// Loads append at the first free cell. Synchronous reset empties the table.
// busy covers the row and the response cycle; the receiver cannot stall.
module nearest_grid_region_lookup #(
   parameter int MAX_REGIONS = ngrl_pkg::MAX_REGIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic signed [10:0] req_cell_x,
   input  logic signed [10:0] req_cell_y,
   input  logic signed [19:0] req_point_x,
   input  logic signed [19:0] req_point_y,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [21:0] rsp_grid_key,
   output logic signed [10:0] rsp_found_x,
   output logic signed [10:0] rsp_found_y
);

   localparam int CW = $clog2(MAX_REGIONS + 1);

   ngrl_pkg::probe_type chain [0:MAX_REGIONS];
   logic [MAX_REGIONS-1:0] wr_en;
   logic                   clear;

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [21:0] key_ff;
   logic        strobe_ff;
   logic [2:0]  status_ff;
   logic [21:0] id_ff;
   logic        cells_ff;
   logic        accept, done;
   logic [21:0] key_c;
   logic signed [20:0] tx, ty;
   logic signed [10:0] cx, cy;

   assign accept = start && !busy;
   assign done   = busy_ff && chain[MAX_REGIONS].valid;

   always_comb begin
      tx = 21'(req_point_x) + 21'sd2048;
      ty = 21'(req_point_y) + 21'sd2048;
      cx = 11'(tx >>> 12);
      cy = 11'(ty >>> 12);
      key_c = (req_op == ngrl_pkg::OP_QUERY) ? ngrl_pkg::pack_id(cx, cy)
                                             : ngrl_pkg::pack_id(req_cell_x, req_cell_y);
      chain[0]          = '0;
      chain[0].valid    = accept &&
                          (req_op == ngrl_pkg::OP_LOAD || req_op == ngrl_pkg::OP_QUERY);
      chain[0].is_query = req_op == ngrl_pkg::OP_QUERY;
      chain[0].key      = key_c;
      chain[0].px       = req_point_x;
      chain[0].py       = req_point_y;
      busy_in = busy_ff;
      if (accept && chain[0].valid) busy_in = 1'b1;
      if (done) busy_in = 1'b0;
      clear = accept && req_op == ngrl_pkg::OP_CLEAR;
      cnt_in = clear ? '0 : cnt_ff;
      wr_en = '0;
      if (done && op_ff == ngrl_pkg::OP_LOAD && !chain[MAX_REGIONS].match &&
          cnt_ff < CW'(MAX_REGIONS)) begin
         wr_en[cnt_ff[$clog2(MAX_REGIONS > 1 ? MAX_REGIONS : 2)-1:0]] = 1'b1;
         cnt_in = cnt_ff + CW'(1);
      end
   end

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      ngrl_cell u_cell (
         .clock(clock), .reset(reset), .clear(clear), .wr_en(wr_en[i]), .wr_id(key_ff),
         .probe_in(chain[i]), .probe_out(chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= (accept && !chain[0].valid) || done;
      end
      if (accept) begin
         op_ff  <= req_op;
         key_ff <= key_c;
      end
      if (accept && !chain[0].valid) begin
         status_ff <= ngrl_pkg::ST_OK;
         id_ff     <= '0;
         cells_ff  <= 1'b0;
      end else if (done) begin
         cells_ff <= 1'b1;
         id_ff    <= key_ff;
         if (op_ff == ngrl_pkg::OP_LOAD) begin
            status_ff <= (!chain[MAX_REGIONS].match && cnt_ff >= CW'(MAX_REGIONS))
                         ? ngrl_pkg::ST_FULL : ngrl_pkg::ST_OK;
         end else if (cnt_ff == '0) begin
            status_ff <= ngrl_pkg::ST_EMPTY;
            id_ff     <= '0;
            cells_ff  <= 1'b0;
         end else if (chain[MAX_REGIONS].match) begin
            status_ff <= ngrl_pkg::ST_HIT;
         end else begin
            status_ff <= ngrl_pkg::ST_NEAREST;
            id_ff     <= chain[MAX_REGIONS].best_id;
         end
      end
   end

   assign busy         = busy_ff || strobe_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_grid_key = id_ff;
   assign rsp_found_x  = cells_ff ? ngrl_pkg::id_gx(id_ff) : '0;
   assign rsp_found_y  = cells_ff ? ngrl_pkg::id_gy(id_ff) : '0;

endmodule

/* tb/nearest_grid_region_lookup_tb.sv */
module nearest_grid_region_lookup_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = ngrl_pkg::MAX_REGIONS_DEF;

   typedef struct packed {
      logic [2:0]                  status;
      logic [ngrl_pkg::ID_W-1:0]   grid_key;
      logic [ngrl_pkg::CELL_W-1:0] found_x;
      logic [ngrl_pkg::CELL_W-1:0] found_y;
   } lookup_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = ngrl_pkg::OP_CLEAR;
   logic signed [10:0] req_cell_x = '0;
   logic signed [10:0] req_cell_y = '0;
   logic signed [19:0] req_point_x = '0;
   logic signed [19:0] req_point_y = '0;
   logic rsp_strobe;
   logic [2:0] rsp_status;
   logic [21:0] rsp_grid_key;
   logic signed [10:0] rsp_found_x;
   logic signed [10:0] rsp_found_y;

   logic [ngrl_pkg::ID_W-1:0] model_cells[TABLE_DEPTH];
   int unsigned model_count = 0;
   lookup_rsp_type expected_rsps[$];
   int unsigned errors = 0;
   int unsigned n_loads = 0, n_queries = 0, n_clears = 0, n_hits = 0, n_near = 0;
   int unsigned n_full = 0;

   nearest_grid_region_lookup dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [ngrl_pkg::ID_W-1:0] id_from_cells(
         input logic signed [ngrl_pkg::CELL_W-1:0] gx,
         input logic signed [ngrl_pkg::CELL_W-1:0] gy);
      return {gx ^ 11'h400, gy ^ 11'h400};
   endfunction

   function automatic longint cell_of_point(input longint p);
      longint t;
      t = p + 2048;
      return t >>> 12;
   endfunction

   function automatic lookup_rsp_type with_cells(input logic [2:0] st,
                                                 input logic [ngrl_pkg::ID_W-1:0] id);
      lookup_rsp_type r;
      r.status = st;
      r.grid_key = id;
      r.found_x = id[21:11] ^ 11'h400;
      r.found_y = id[10:0] ^ 11'h400;
      return r;
   endfunction

   function automatic lookup_rsp_type predict_lookup(input logic [1:0] op,
                                                     input logic signed [10:0] cx,
                                                     input logic signed [10:0] cy,
                                                     input logic signed [19:0] px,
                                                     input logic signed [19:0] py);
      lookup_rsp_type r;
      logic [ngrl_pkg::ID_W-1:0] id, best_id;
      longint gx, gy, dx, dy;
      longint unsigned d, best_d;
      r = '0;
      if (op == ngrl_pkg::OP_LOAD) begin
         id = id_from_cells(cx, cy);
         n_loads++;
         for (int i = 0; i < model_count; i++)
            if (model_cells[i] == id) return with_cells(ngrl_pkg::ST_OK, id);
         if (model_count >= TABLE_DEPTH) begin
            n_full++;
            return with_cells(ngrl_pkg::ST_FULL, id);
         end
         model_cells[model_count] = id;
         model_count++;
         return with_cells(ngrl_pkg::ST_OK, id);
      end
      if (op == ngrl_pkg::OP_QUERY) begin
         n_queries++;
         if (model_count == 0) begin
            r.status = ngrl_pkg::ST_EMPTY;
            return r;
         end
         id = {11'(cell_of_point(px) + 1024), 11'(cell_of_point(py) + 1024)};
         for (int i = 0; i < model_count; i++)
            if (model_cells[i] == id) begin
               n_hits++;
               return with_cells(ngrl_pkg::ST_HIT, id);
            end
         best_d = 0;
         best_id = '0;
         for (int i = 0; i < model_count; i++) begin
            gx = longint'(model_cells[i][21:11]) - 1024;
            gy = longint'(model_cells[i][10:0]) - 1024;
            dx = longint'(px) - gx * 4096;
            dy = longint'(py) - gy * 4096;
            d = dx * dx + dy * dy;
            if (i == 0 || d < best_d) begin
               best_d = d;
               best_id = model_cells[i];
            end
         end
         n_near++;
         return with_cells(ngrl_pkg::ST_NEAREST, best_id);
      end
      if (op == ngrl_pkg::OP_CLEAR) begin
         n_clears++;
         model_count = 0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_rsp_type got, want;
      if (!reset && rsp_strobe) begin
         got = {rsp_status, rsp_grid_key, rsp_found_x, rsp_found_y};
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status) begin
               $display("%0t status exp %0d got %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.grid_key !== want.grid_key) begin
               $display("%0t grid_key exp %h got %h", $time, want.grid_key, got.grid_key);
               errors++;
            end
            if (got.found_x !== want.found_x) begin
               $display("%0t found_x exp %h got %h", $time, want.found_x, got.found_x);
               errors++;
            end
            if (got.found_y !== want.found_y) begin
               $display("%0t found_y exp %h got %h", $time, want.found_y, got.found_y);
               errors++;
            end
         end
      end
   end

   // start stays high after accept until the next request or a drain; busy
   // holds off a second accept meanwhile
   task automatic send_request(input logic [1:0] op, input logic signed [10:0] cx,
                               input logic signed [10:0] cy, input logic signed [19:0] px,
                               input logic signed [19:0] py, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_cell_x <= cx;
      req_cell_y <= cy;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsps.push_back(predict_lookup(op, cx, cy, px, py));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [19:0] near_cell_point(input logic signed [10:0] c);
      return 20'(longint'(c) * 4096 + $signed($urandom_range(0, 8190)) - 4095);
   endfunction

   task automatic test_directed();
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh7FFFF, 20'sh80000);
      send_request(ngrl_pkg::OP_LOAD, -1024, 1023, 0, 0);
      send_request(ngrl_pkg::OP_LOAD, 1023, -1024, 0, 0);
      send_request(ngrl_pkg::OP_LOAD, 1023, -1024, 0, 0);
      send_request(ngrl_pkg::OP_LOAD, 0, 0, 0, 0);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh007FF, -20'sd2048);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh00800, 20'sh00800);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh7FFFF, 20'sh7FFFF);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh80000, 20'sh80000);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh80000, 20'sh7FFFF);
      send_request(ngrl_pkg::OP_NONE, 5, 5, 20'sh12345, 20'sh54321);
      send_request(ngrl_pkg::OP_CLEAR, 7, 7, 0, 0);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 0, 0);
      send_request(ngrl_pkg::OP_LOAD, 2, 0, 0, 0);
      send_request(ngrl_pkg::OP_LOAD, -2, 0, 0, 0);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 0, 0);
      send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'sh10000, 20'sh10000);
      wait_drained();
   endtask

   task automatic test_fill_table();
      send_request(ngrl_pkg::OP_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < TABLE_DEPTH + 4; i++)
         send_request(ngrl_pkg::OP_LOAD, 11'(i * 7 - 900), 11'(i * 3 - 400), 0, 0,
                      i % 3 == 0);
      send_request(ngrl_pkg::OP_LOAD, -900, -400, 0, 0);
      for (int i = 0; i < 10; i++)
         send_request(ngrl_pkg::OP_QUERY, 0, 0, 20'($urandom), 20'($urandom));
      wait_drained();
   endtask

   task automatic test_random();
      logic signed [10:0] cx, cy;
      int pick;
      for (int i = 0; i < 1700; i++) begin
         if (i == 850) wait_drained();
         pick = $urandom_range(0, 99);
         cx = $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($signed($urandom_range(0, 15)) - 8);
         cy = $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($signed($urandom_range(0, 15)) - 8);
         if (pick < 1)
            send_request(ngrl_pkg::OP_CLEAR, cx, cy, 20'($urandom), 20'($urandom),
                         i % 40 < 8);
         else if (pick < 3)
            send_request(ngrl_pkg::OP_NONE, cx, cy, 20'($urandom), 20'($urandom),
                         i % 40 < 8);
         else if (pick < 35)
            send_request(ngrl_pkg::OP_LOAD, cx, cy, 20'($urandom), 20'($urandom),
                         i % 40 < 8);
         else if (pick < 80)
            send_request(ngrl_pkg::OP_QUERY, cx, cy, near_cell_point(cx),
                         near_cell_point(cy), i % 40 < 8);
         else
            send_request(ngrl_pkg::OP_QUERY, cx, cy, 20'($urandom), 20'($urandom),
                         i % 40 < 8);
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_table();
      test_random();
      repeat (TABLE_DEPTH + 20) @(posedge clock);
      $display("covered %0d loads (%0d refused full), %0d clears, %0d queries",
               n_loads, n_full, n_clears, n_queries);
      $display("queries: %0d exact cell hits, %0d nearest by distance", n_hits, n_near);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
